// File: hdl/mlf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlf_pkg
// Shared types and fixed field widths for the MAC learning forwarder.
// ----------------------------------------------------------------------------
package mlf_pkg;

   localparam int MAC_W  = 48;
   localparam int PORT_W = 4;
   localparam int MASK_W = 16;
   localparam int CFG_W  = 5;

   localparam logic [CFG_W-1:0] NUM_PORTS_RESET = 5'd2;

   typedef logic [MAC_W-1:0]  mac_type;
   typedef logic [PORT_W-1:0] port_type;
   typedef logic [MASK_W-1:0] mask_type;
   typedef logic [CFG_W-1:0]  cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage : mlf_pkg
`default_nettype wire

// File: hdl/mac_learning_forwarder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mac_learning_forwarder_top
// Layer-2 address learning and forwarding: one sequential pass over the
// address table matches both keys, then learns the source and forms the mask.
// ----------------------------------------------------------------------------
// the result strobe follows a scan of the fill learned entries (fill at
//   most TABLE_ENTRIES) and the finish state that forms the result
// transactions are taken one at a time: busy holds off a new one until
//   its result is formed; the table's single read port is scanned one entry per cycle
// reset: table empty (fill count zero), num_ports = 2, block idle
// results are not back-pressured: each strobe lasts exactly one cycle
module mac_learning_forwarder_top #(
   parameter int TABLE_ENTRIES = 32,
   parameter int MAX_PORTS     = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   start,
   output logic                  busy,
   input  wire  mlf_pkg::mac_type  req_src_mac,
   input  wire  mlf_pkg::mac_type  req_dst_mac,
   input  wire  mlf_pkg::port_type req_ingress_port,
   // result channel
   output logic                  rsp_strobe,
   output mlf_pkg::mask_type     rsp_egress_mask,
   output logic                  rsp_flooded,
   output logic                  rsp_learned,
   output logic                  rsp_table_full,
   // configuration write channel
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  mlf_pkg::cfg_type  csr_num_ports
);
   import mlf_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = MAC_W + PORT_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
   localparam cfg_type       PORT_LIMIT = CFG_W'(MAX_PORTS);

   // table memory: {port, mac} per entry, entries below the fill count valid
   logic [EW-1:0] table_mem [TABLE_ENTRIES];
   logic [EW-1:0] rd_data_ff;

   state_type     state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rd_vld_ff;
   cfg_type       num_ports_ff, num_ports_in;

   mac_type       src_ff, dst_ff;
   port_type      port_ff;
   logic          src_hit_ff, src_hit_in;
   logic          dst_hit_ff, dst_hit_in;
   port_type      dst_port_ff, dst_port_in;

   logic          strobe_ff;
   mask_type      mask_ff, mask_in;
   logic          flooded_ff, flooded_in;
   logic          learned_ff, learned_in;
   logic          full_ff, full_in;

   logic          accept;
   logic          rd_en;
   logic          finish;
   logic          scan_done;
   logic          src_match, dst_match;
   logic          learn;
   logic          hit;
   port_type      hit_port;
   port_type      partner;
   cfg_type       limit;
   mask_type      flood_mask;

   assign accept    = start && !busy;
   assign scan_done = (idx_ff == fill_ff);
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy   = 1'b1;
      rd_en  = 1'b0;
      finish = 1'b0;
      case (state_ff)
         ST_IDLE:   busy   = 1'b0;
         ST_SCAN:   rd_en  = !scan_done;
         ST_FINISH: finish = 1'b1;
         default:   busy   = 1'b1;
      endcase
   end

   // compare the entry read in the previous cycle against both keys
   always_comb begin
      src_match   = rd_vld_ff && (rd_data_ff[MAC_W-1:0] == src_ff);
      dst_match   = rd_vld_ff && (rd_data_ff[MAC_W-1:0] == dst_ff);
      src_hit_in  = accept ? 1'b0 : (src_hit_ff | src_match);
      dst_hit_in  = accept ? 1'b0 : (dst_hit_ff | dst_match);
      dst_port_in = dst_match ? rd_data_ff[EW-1:MAC_W] : dst_port_ff;
      idx_in      = accept ? '0 : (rd_en ? idx_ff + 1'b1 : idx_ff);
   end

   // learn, then forward; a destination equal to a just-learned source hits
   always_comb begin
      learn    = !src_hit_ff && (fill_ff < FULL_COUNT);
      hit      = dst_hit_ff || (learn && (dst_ff == src_ff));
      hit_port = dst_hit_ff ? dst_port_ff : port_ff;
      partner  = port_ff ^ PORT_W'(1);
      limit    = (num_ports_ff > PORT_LIMIT) ? PORT_LIMIT : num_ports_ff;
      for (int j = 0; j < MASK_W; j++) begin
         flood_mask[j] = (CFG_W'(j) < limit) && (PORT_W'(j) != port_ff)
                         && (PORT_W'(j) != partner);
      end
      flood_mask[partner] = 1'b1;

      mask_in    = hit ? (MASK_W'(1) << hit_port) : flood_mask;
      flooded_in = !hit;
      learned_in = learn;
      full_in    = !src_hit_ff && !learn;
      fill_in    = (finish && learn) ? fill_ff + 1'b1 : fill_ff;
      num_ports_in = (csr_valid && csr_ready) ? csr_num_ports : num_ports_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         num_ports_ff <= NUM_PORTS_RESET;
         strobe_ff    <= 1'b0;
         src_hit_ff   <= 1'b0;
         dst_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_en;
         num_ports_ff <= num_ports_in;
         strobe_ff    <= finish;
         src_hit_ff   <= src_hit_in;
         dst_hit_ff   <= dst_hit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff  <= req_src_mac;
         dst_ff  <= req_dst_mac;
         port_ff <= req_ingress_port;
      end
      dst_port_ff <= dst_port_in;
      if (finish) begin
         mask_ff    <= mask_in;
         flooded_ff <= flooded_in;
         learned_ff <= learned_in;
         full_ff    <= full_in;
      end
   end

   // table memory ports
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= table_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (finish && learn) table_mem[fill_ff[AW-1:0]] <= {port_ff, src_ff};
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_egress_mask = mask_ff;
   assign rsp_flooded     = flooded_ff;
   assign rsp_learned     = learned_ff;
   assign rsp_table_full  = full_ff;

endmodule : mac_learning_forwarder_top
`default_nettype wire

// File: tb/sv/mac_learning_forwarder_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mac_learning_forwarder_checker
// Watches the request, result and register channels of the forwarder, keeps
// its own copy of the address table, predicts the egress mask and flags of
// every accepted frame and compares them in order with the result strobes.
// ----------------------------------------------------------------------------
module mac_learning_forwarder_checker #(
   parameter int TABLE_ENTRIES = 32,
   parameter int MAX_PORTS     = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire                     busy,
   input  wire  mlf_pkg::mac_type  req_src_mac,
   input  wire  mlf_pkg::mac_type  req_dst_mac,
   input  wire  mlf_pkg::port_type req_ingress_port,
   input  wire                     rsp_strobe,
   input  wire  mlf_pkg::mask_type rsp_egress_mask,
   input  wire                     rsp_flooded,
   input  wire                     rsp_learned,
   input  wire                     rsp_table_full,
   input  wire                     csr_valid,
   input  wire                     csr_ready,
   input  wire  mlf_pkg::cfg_type  csr_num_ports,
   output int                      fail_count,
   output int                      open_count
);
   import mlf_pkg::*;

   typedef struct packed {
      mask_type egress_mask;
      logic     flooded;
      logic     learned;
      logic     table_full;
   } fwd_result_type;

   mac_type        addr_keys [TABLE_ENTRIES];
   port_type       addr_ports[TABLE_ENTRIES];
   logic           addr_used [TABLE_ENTRIES];
   int             addr_fill;
   cfg_type        num_ports_cfg;
   fwd_result_type forward_q[$];

   initial begin
      fail_count = 0;
      open_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic int lookup_entry(input mac_type key);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (addr_used[i] && addr_keys[i] == key) return i;
      end
      return -1;
   endfunction

   // learn the source first, so the destination lookup sees this frame's entry
   function automatic fwd_result_type forward_frame(input mac_type src, input mac_type dst,
                                                    input port_type ingress);
      fwd_result_type res;
      port_type       partner;
      int             hit;
      int             limit;
      res     = '0;
      partner = ingress ^ port_type'(1);
      if (lookup_entry(src) < 0) begin
         if (addr_fill < TABLE_ENTRIES) begin
            addr_keys[addr_fill]  = src;
            addr_ports[addr_fill] = ingress;
            addr_used[addr_fill]  = 1'b1;
            addr_fill++;
            res.learned = 1'b1;
         end else begin
            res.table_full = 1'b1;
         end
      end
      hit = lookup_entry(dst);
      if (hit >= 0) begin
         res.egress_mask[addr_ports[hit]] = 1'b1;
      end else begin
         limit = (int'(num_ports_cfg) > MAX_PORTS) ? MAX_PORTS : int'(num_ports_cfg);
         for (int j = 0; j < limit && j < MASK_W; j++) begin
            if (j != int'(ingress) && j != int'(partner)) res.egress_mask[j] = 1'b1;
         end
         // the partner port is flooded even when it lies above num_ports
         res.egress_mask[partner] = 1'b1;
         res.flooded = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      fwd_result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) addr_used[i] = 1'b0;
         addr_fill     = 0;
         num_ports_cfg = NUM_PORTS_RESET;
         forward_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (forward_q.size() == 0) begin
               report_mismatch($sformatf("result with no transaction outstanding, mask %h",
                                         rsp_egress_mask));
            end else begin
               want = forward_q.pop_front();
               if (rsp_egress_mask !== want.egress_mask)
                  report_mismatch($sformatf("egress_mask expected %h got %h",
                                            want.egress_mask, rsp_egress_mask));
               if (rsp_flooded !== want.flooded)
                  report_mismatch($sformatf("flooded expected %b got %b",
                                            want.flooded, rsp_flooded));
               if (rsp_learned !== want.learned)
                  report_mismatch($sformatf("learned expected %b got %b",
                                            want.learned, rsp_learned));
               if (rsp_table_full !== want.table_full)
                  report_mismatch($sformatf("table_full expected %b got %b",
                                            want.table_full, rsp_table_full));
            end
         end
         if (start && !busy)
            forward_q.push_back(forward_frame(req_src_mac, req_dst_mac, req_ingress_port));
         if (csr_valid && csr_ready) num_ports_cfg = csr_num_ports;
      end
      open_count <= forward_q.size();
   end

endmodule : mac_learning_forwarder_checker
`default_nettype wire

// File: tb/sv/mac_learning_forwarder_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mac_learning_forwarder_top_test
// Drives frame headers and num_ports writes into the forwarder: a directed
// pass over the flooding corner cases, then three random phases with
// different sender gaps, draining and rewriting num_ports between chunks.
// ----------------------------------------------------------------------------
module mac_learning_forwarder_top_test;
   import mlf_pkg::*;

   localparam int TABLE_ENTRIES    = 32;
   localparam int MAX_PORTS        = 16;
   localparam int FRAMES_PER_PHASE = 570;
   localparam int DRAIN_EVERY      = 150;
   localparam int TAIL_CYCLES      = 40;
   localparam int STALL_LIMIT      = 2000;
   localparam mac_type MAC_ONES    = '1;

   logic     clock            = 1'b0;
   logic     reset            = 1'b1;
   logic     start            = 1'b0;
   mac_type  req_src_mac      = '0;
   mac_type  req_dst_mac      = '0;
   port_type req_ingress_port = '0;
   logic     csr_valid        = 1'b0;
   cfg_type  csr_num_ports    = NUM_PORTS_RESET;

   logic     busy;
   logic     rsp_strobe;
   mask_type rsp_egress_mask;
   logic     rsp_flooded;
   logic     rsp_learned;
   logic     rsp_table_full;
   logic     csr_ready;

   int       fail_count;
   int       open_count;
   int       stall_cycles = 0;
   mac_type  seen_src[$];

   always #5 clock = ~clock;

   mac_learning_forwarder_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_PORTS    (MAX_PORTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_src_mac     (req_src_mac),
      .req_dst_mac     (req_dst_mac),
      .req_ingress_port(req_ingress_port),
      .rsp_strobe      (rsp_strobe),
      .rsp_egress_mask (rsp_egress_mask),
      .rsp_flooded     (rsp_flooded),
      .rsp_learned     (rsp_learned),
      .rsp_table_full  (rsp_table_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_num_ports   (csr_num_ports)
   );

   mac_learning_forwarder_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_PORTS    (MAX_PORTS)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_src_mac     (req_src_mac),
      .req_dst_mac     (req_dst_mac),
      .req_ingress_port(req_ingress_port),
      .rsp_strobe      (rsp_strobe),
      .rsp_egress_mask (rsp_egress_mask),
      .rsp_flooded     (rsp_flooded),
      .rsp_learned     (rsp_learned),
      .rsp_table_full  (rsp_table_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_num_ports   (csr_num_ports),
      .fail_count      (fail_count),
      .open_count      (open_count)
   );

   // watchdog: any accepted transaction or result resets the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic mac_type rand_mac();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[MAC_W-1:0];
   endfunction

   task automatic send_frame(input mac_type src, input mac_type dst, input port_type ingress);
      bit known;
      known = 1'b0;
      foreach (seen_src[i]) if (seen_src[i] == src) known = 1'b1;
      if (!known) seen_src.push_back(src);
      start            <= 1'b1;
      req_src_mac      <= src;
      req_dst_mac      <= dst;
      req_ingress_port <= ingress;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (open_count != 0 || busy);
   endtask

   task automatic write_num_ports(input cfg_type value);
      drain();
      csr_valid     <= 1'b1;
      csr_num_ports <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly known sources and learned destinations, so hits and repeats dominate
   task automatic random_frame();
      mac_type  src;
      mac_type  dst;
      int       pick;
      int       hit_span;
      hit_span = (seen_src.size() < 40) ? seen_src.size() : 40;
      if ($urandom_range(99) < 70) src = seen_src[$urandom_range(0, seen_src.size() - 1)];
      else src = rand_mac();
      pick = $urandom_range(99);
      if (pick < 50)      dst = seen_src[$urandom_range(0, hit_span - 1)];
      else if (pick < 60) dst = src;
      else if (pick < 64) dst = $urandom_range(1) ? MAC_ONES : '0;
      else                dst = rand_mac();
      send_frame(src, dst, port_type'($urandom_range(0, 15)));
   endtask

   initial begin
      int idle_pct;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: learning, hits, and flooding corners at reset and written num_ports
      send_frame('0, '0, 4'd0);
      send_frame(MAC_ONES, rand_mac(), 4'd15);
      send_frame('0, MAC_ONES, 4'd3);
      send_frame(48'h0A0B_0C0D_0E0F, 48'h0A0B_0C0D_0E0F, 4'd9);
      send_frame(48'h0000_0000_0001, 48'h0A0B_0C0D_0E0F, 4'd2);
      write_num_ports(5'd0);
      send_frame(rand_mac(), rand_mac(), 4'd6);
      send_frame(rand_mac(), rand_mac(), 4'd15);
      write_num_ports(5'd31);
      send_frame(rand_mac(), rand_mac(), 4'd0);
      send_frame(rand_mac(), rand_mac(), 4'd15);
      write_num_ports(5'd16);
      send_frame(rand_mac(), rand_mac(), 4'd7);
      send_frame(48'h8000_0000_0000, 48'h0000_0000_0001, 4'd11);
      write_num_ports(5'd17);
      send_frame(rand_mac(), rand_mac(), 4'd4);
      write_num_ports(5'd1);
      send_frame(rand_mac(), rand_mac(), 4'd14);
      send_frame(rand_mac(), rand_mac(), 4'd1);
      send_frame(rand_mac(), rand_mac(), 4'd0);
      write_num_ports(5'd3);
      send_frame(rand_mac(), rand_mac(), 4'd15);
      send_frame(rand_mac(), rand_mac(), 4'd5);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               idle_pct = 37;
               write_num_ports(cfg_type'($urandom_range(3, 15)));
            end
            1: begin
               idle_pct = 67;
               write_num_ports(5'd31);
            end
            default: begin
               idle_pct = 0;
               write_num_ports(5'd16);
            end
         endcase
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            // sender waits for every outstanding result, then num_ports changes
            if (n > 0 && n % DRAIN_EVERY == 0)
               write_num_ports(cfg_type'($urandom_range(0, 31)));
            random_frame();
            if ($urandom_range(99) < idle_pct)
               pause_sender(($urandom_range(3) == 0) ? $urandom_range(1, 45)
                                                     : $urandom_range(1, 6));
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && open_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule : mac_learning_forwarder_top_test
`default_nettype wire
